[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// implication checked in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/mcts_pkg.sv]
// ---------------------------------------------------------------------------
// mcts_pkg
// shared types and constants of the thread scheduler
// ---------------------------------------------------------------------------
package mcts_pkg;

	localparam int NUM_THREADS = 16;
	localparam int NUM_LOCKS   = 8;
	localparam int NUM_CVS     = 8;
	localparam int TH_W        = $clog2(NUM_THREADS);
	localparam int LK_W        = $clog2(NUM_LOCKS);
	localparam int CV_W        = $clog2(NUM_CVS);
	localparam int KEY_W       = 32;
	localparam int IN_W        = 72;
	localparam int OUT_W       = 16;

	typedef logic [TH_W-1:0] th_t;
	typedef logic [LK_W-1:0] lk_t;
	typedef logic [CV_W-1:0] cv_t;

	typedef enum logic [3:0] {
		OP_INIT   = 4'd0,
		OP_CREATE = 4'd1,
		OP_YIELD  = 4'd2,
		OP_LOCK   = 4'd3,
		OP_UNLOCK = 4'd4,
		OP_WAIT   = 4'd5,
		OP_SIGNAL = 4'd6,
		OP_BCAST  = 4'd7,
		OP_EXIT   = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOINIT   = 3'd1,
		ST_REINIT   = 3'd2,
		ST_OWNER    = 3'd3,
		ST_NOTOWNER = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [7:0] {
		CMD_NONE  = 8'b0000_0000,
		CMD_LATCH = 8'b0000_0001,
		CMD_FIND  = 8'b0000_0010,
		CMD_FIND2 = 8'b0000_0100,
		CMD_EXEC  = 8'b0000_1000,
		CMD_DISP  = 8'b0001_0000,
		CMD_POP   = 8'b0010_0000,
		CMD_FREE  = 8'b0100_0000,
		CMD_EMIT  = 8'b1000_0000
	} cmd_t;

	typedef struct packed {
		logic disp;
		logic pop;
		logic bcast;
		logic free;
		logic disp_end;
		logic cv_last;
		logic out_free;
	} dp_status_t;

endpackage

[rtl/core/mcts_ctrl.sv]
// ---------------------------------------------------------------------------
// mcts_ctrl
// sequencer that steps the datapath through one request
// ---------------------------------------------------------------------------
module mcts_ctrl
	import mcts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t sts,
	output cmd_t       cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_FIND  = 9'b000000010,
		S_FIND2 = 9'b000000100,
		S_EXEC  = 9'b000001000,
		S_ROUTE = 9'b000010000,
		S_DISP  = 9'b000100000,
		S_POP   = 9'b001000000,
		S_FREE  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_LATCH;
					state_d = S_FIND;
				end
			end
			S_FIND: begin
				cmd     = CMD_FIND;
				state_d = S_FIND2;
			end
			S_FIND2: begin
				cmd     = CMD_FIND2;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd     = CMD_EXEC;
				state_d = S_ROUTE;
			end
			S_ROUTE: begin
				priority if (sts.pop) state_d = S_POP;
				else if (sts.disp) state_d = S_DISP;
				else if (sts.free) state_d = S_FREE;
				else state_d = S_OUT;
			end
			S_DISP: begin
				cmd = CMD_DISP;
				if (sts.disp_end) state_d = S_OUT;
			end
			S_POP: begin
				cmd = CMD_POP;
				if (!sts.bcast || sts.cv_last) state_d = S_OUT;
			end
			S_FREE: begin
				cmd     = CMD_FREE;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd     = CMD_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/mcts_dp.sv]
// ---------------------------------------------------------------------------
// mcts_dp
// thread, lock and condition tables with their queue operations
// ---------------------------------------------------------------------------
module mcts_dp
	import mcts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [IN_W-1:0]  in_data,
	output dp_status_t       sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	logic [3:0]       op_q;
	logic [KEY_W-1:0] lock_q;
	logic [KEY_W-1:0] cond_q;
	lk_t              e_q, fe_q;
	logic             e_hit_q, fe_ok_q;
	th_t              fs_q;
	logic             fs_ok_q;
	cv_t              c_q, fc_q;
	logic             c_hit_q, fc_ok_q;
	logic             disp_q, pop_q, free_q;
	status_t          status_q;
	th_t              newt_q;

	logic             init_q, done_q, pres_q;
	th_t              run_q;
	logic             in_use_q [NUM_THREADS];
	th_t              next_q   [NUM_THREADS];
	logic             relock_q [NUM_THREADS];
	lk_t              rentry_q [NUM_THREADS];
	th_t              rdy_head_q, rdy_tail_q;
	logic             rdy_ne_q;
	logic             lk_valid_q [NUM_LOCKS];
	logic [KEY_W-1:0] lk_key_q   [NUM_LOCKS];
	logic             lk_owned_q [NUM_LOCKS];
	th_t              lk_owner_q [NUM_LOCKS];
	th_t              lw_head_q  [NUM_LOCKS];
	th_t              lw_tail_q  [NUM_LOCKS];
	logic             lw_ne_q    [NUM_LOCKS];
	logic             cv_valid_q [NUM_CVS];
	lk_t              cv_lock_q  [NUM_CVS];
	logic [KEY_W-1:0] cv_cond_q  [NUM_CVS];
	th_t              cv_head_q  [NUM_CVS];
	th_t              cv_tail_q  [NUM_CVS];

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic hit_e, ok_fe, ok_fs, hit_c, ok_fc, owns, lk_busy;
	lk_t  he, hfe;
	th_t  hfs;
	cv_t  hc, hfc, cx;
	th_t  w_lw, rh, ch;
	lk_t  ee;

	always_comb begin
		hit_e = 1'b0; he = '0; ok_fe = 1'b0; hfe = '0;
		for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
			if (lk_valid_q[i] && lk_key_q[i] == lock_q) begin
				hit_e = 1'b1; he = LK_W'(i);
			end
			if (!lk_valid_q[i]) begin
				ok_fe = 1'b1; hfe = LK_W'(i);
			end
		end
		ok_fs = 1'b0; hfs = '0;
		for (int i = NUM_THREADS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				ok_fs = 1'b1; hfs = TH_W'(i);
			end
		end
		hit_c = 1'b0; hc = '0; ok_fc = 1'b0; hfc = '0;
		for (int i = NUM_CVS - 1; i >= 0; i--) begin
			if (cv_valid_q[i] && cv_lock_q[i] == e_q && cv_cond_q[i] == cond_q) begin
				hit_c = 1'b1; hc = CV_W'(i);
			end
			if (!cv_valid_q[i]) begin
				ok_fc = 1'b1; hfc = CV_W'(i);
			end
		end
		lk_busy = lk_owned_q[e_q] || lw_ne_q[e_q];
		for (int i = 0; i < NUM_CVS; i++)
			if (cv_valid_q[i] && cv_lock_q[i] == e_q) lk_busy = 1'b1;
		for (int i = 0; i < NUM_THREADS; i++)
			if (in_use_q[i] && relock_q[i] && rentry_q[i] == e_q) lk_busy = 1'b1;
	end

	assign owns = e_hit_q && pres_q && lk_owned_q[e_q] && lk_owner_q[e_q] == run_q;
	assign cx   = c_hit_q ? c_q : fc_q;
	assign w_lw = lw_head_q[e_q];
	assign rh   = rdy_head_q;
	assign ch   = cv_head_q[c_q];
	assign ee   = rentry_q[rh];

	assign sts.disp     = disp_q;
	assign sts.pop      = pop_q;
	assign sts.bcast    = (op_q == OP_BCAST);
	assign sts.free     = free_q;
	assign sts.disp_end = !rdy_ne_q || !(relock_q[rh] && lk_owned_q[ee]);
	assign sts.cv_last  = (ch == cv_tail_q[c_q]);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= 1'b0;
			done_q      <= 1'b0;
			pres_q      <= 1'b0;
			run_q       <= '0;
			rdy_ne_q    <= 1'b0;
			rdy_head_q  <= '0;
			rdy_tail_q  <= '0;
			disp_q      <= 1'b0;
			pop_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_THREADS; i++) begin
				in_use_q[i] <= 1'b0;
				relock_q[i] <= 1'b0;
			end
			for (int i = 0; i < NUM_LOCKS; i++) lk_valid_q[i] <= 1'b0;
			for (int i = 0; i < NUM_CVS; i++) cv_valid_q[i] <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && cmd != CMD_EMIT) out_valid_q <= 1'b0;
			unique case (cmd)
				CMD_NONE: begin
				end
				CMD_LATCH: begin
					op_q     <= in_data[3:0];
					lock_q   <= in_data[35:4];
					cond_q   <= in_data[67:36];
					status_q <= ST_OK;
					newt_q   <= '0;
					disp_q   <= 1'b0;
					pop_q    <= 1'b0;
					free_q   <= 1'b0;
				end
				CMD_FIND: begin
					e_q     <= he;
					e_hit_q <= hit_e;
					fe_q    <= hfe;
					fe_ok_q <= ok_fe;
					fs_q    <= hfs;
					fs_ok_q <= ok_fs;
				end
				CMD_FIND2: begin
					c_q     <= hc;
					c_hit_q <= hit_c;
					fc_q    <= hfc;
					fc_ok_q <= ok_fc;
				end
				CMD_EXEC: begin
					if (op_q == OP_INIT) begin
						if (init_q) status_q <= ST_REINIT;
						else begin
							init_q      <= 1'b1;
							in_use_q[0] <= 1'b1;
							run_q       <= '0;
							pres_q      <= 1'b1;
						end
					end else if (op_q > OP_EXIT) begin
					end else if (!init_q) begin
						status_q <= ST_NOINIT;
					end else if (op_q == OP_CREATE) begin
						if (!fs_ok_q) status_q <= ST_FULL;
						else begin
							in_use_q[fs_q] <= 1'b1;
							relock_q[fs_q] <= 1'b0;
							if (rdy_ne_q) next_q[rdy_tail_q] <= fs_q;
							else rdy_head_q <= fs_q;
							rdy_tail_q <= fs_q;
							rdy_ne_q   <= 1'b1;
							newt_q     <= fs_q;
						end
					end else if (op_q == OP_YIELD) begin
						if (pres_q) begin
							if (rdy_ne_q) next_q[rdy_tail_q] <= run_q;
							else rdy_head_q <= run_q;
							rdy_tail_q <= run_q;
							rdy_ne_q   <= 1'b1;
							disp_q     <= 1'b1;
						end
					end else if (op_q == OP_LOCK) begin
						if (pres_q) begin
							if (owns) status_q <= ST_OWNER;
							else if (!e_hit_q) begin
								if (!fe_ok_q) status_q <= ST_FULL;
								else begin
									lk_valid_q[fe_q] <= 1'b1;
									lk_key_q[fe_q]   <= lock_q;
									lk_owned_q[fe_q] <= 1'b1;
									lk_owner_q[fe_q] <= run_q;
									lw_ne_q[fe_q]    <= 1'b0;
								end
							end else if (!lk_owned_q[e_q]) begin
								lk_owned_q[e_q] <= 1'b1;
								lk_owner_q[e_q] <= run_q;
							end else begin
								if (lw_ne_q[e_q]) next_q[lw_tail_q[e_q]] <= run_q;
								else lw_head_q[e_q] <= run_q;
								lw_tail_q[e_q] <= run_q;
								lw_ne_q[e_q]   <= 1'b1;
								disp_q         <= 1'b1;
							end
						end
					end else if (op_q == OP_UNLOCK || op_q == OP_WAIT) begin
						if (!owns) status_q <= ST_NOTOWNER;
						else if (op_q == OP_WAIT && !c_hit_q && !fc_ok_q) status_q <= ST_FULL;
						else begin
							if (lw_ne_q[e_q]) begin
								if (w_lw == lw_tail_q[e_q]) lw_ne_q[e_q] <= 1'b0;
								else lw_head_q[e_q] <= next_q[w_lw];
								lk_owner_q[e_q] <= w_lw;
								if (rdy_ne_q) next_q[rdy_tail_q] <= w_lw;
								else rdy_head_q <= w_lw;
								rdy_tail_q <= w_lw;
								rdy_ne_q   <= 1'b1;
							end else begin
								lk_owned_q[e_q] <= 1'b0;
							end
							if (op_q == OP_UNLOCK) free_q <= 1'b1;
							else begin
								if (cv_valid_q[cx]) next_q[cv_tail_q[cx]] <= run_q;
								else begin
									cv_valid_q[cx] <= 1'b1;
									cv_lock_q[cx]  <= e_q;
									cv_cond_q[cx]  <= cond_q;
									cv_head_q[cx]  <= run_q;
								end
								cv_tail_q[cx]   <= run_q;
								relock_q[run_q] <= 1'b1;
								rentry_q[run_q] <= e_q;
								disp_q          <= 1'b1;
							end
						end
					end else if (op_q == OP_SIGNAL || op_q == OP_BCAST) begin
						if (e_hit_q && c_hit_q) pop_q <= 1'b1;
					end else begin
						if (pres_q) begin
							in_use_q[run_q] <= 1'b0;
							relock_q[run_q] <= 1'b0;
							pres_q          <= 1'b0;
							disp_q          <= 1'b1;
						end
					end
				end
				CMD_DISP: begin
					if (!rdy_ne_q) begin
						pres_q <= 1'b0;
						run_q  <= '0;
						done_q <= 1'b1;
					end else begin
						if (rh == rdy_tail_q) rdy_ne_q <= 1'b0;
						else rdy_head_q <= next_q[rh];
						if (relock_q[rh]) begin
							relock_q[rh] <= 1'b0;
							if (lk_owned_q[ee]) begin
								if (lw_ne_q[ee]) next_q[lw_tail_q[ee]] <= rh;
								else lw_head_q[ee] <= rh;
								lw_tail_q[ee] <= rh;
								lw_ne_q[ee]   <= 1'b1;
							end else begin
								lk_owned_q[ee] <= 1'b1;
								lk_owner_q[ee] <= rh;
								run_q          <= rh;
								pres_q         <= 1'b1;
							end
						end else begin
							run_q  <= rh;
							pres_q <= 1'b1;
						end
					end
				end
				CMD_POP: begin
					if (ch == cv_tail_q[c_q]) cv_valid_q[c_q] <= 1'b0;
					else cv_head_q[c_q] <= next_q[ch];
					if (rdy_ne_q) next_q[rdy_tail_q] <= ch;
					else rdy_head_q <= ch;
					rdy_tail_q <= ch;
					rdy_ne_q   <= 1'b1;
				end
				CMD_FREE: begin
					if (!lk_busy) lk_valid_q[e_q] <= 1'b0;
				end
				CMD_EMIT: begin
					out_valid_q <= 1'b1;
					out_data_q  <= {3'b000, done_q, newt_q, pres_q,
						(pres_q ? run_q : th_t'(0)), status_q};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/mutex_condvar_thread_scheduler_top.sv]
// ---------------------------------------------------------------------------
// mutex_condvar_thread_scheduler_top
// hardware thread scheduler with fifo mutexes and condition variables
// ---------------------------------------------------------------------------
// one request on s_axis carries an opcode, a lock id and a cond id and is
// performed on behalf of the running thread; exactly one result follows on
// m_axis with status, running thread, new thread and the done flag.
// requests are handled one at a time: s_axis_tready is high only while the
// sequencer is idle. a request passes the latch, find, second find, execute
// and route steps, then its extra steps: dispatch steps (each relock-blocked
// thread costs a step), a pop step per thread moved by signal or broadcast,
// the lock entry free check after unlock, and the output step that loads
// the output register. the tables are flip-flops, scanned in parallel
// compares; the queues are walked through one next-pointer read a cycle.
// reset clears all valid bits, the ready queue and the output register;
// the block then answers not initialised until an init request.
// a stalled m_axis holds its result; the sequencer waits in its output
// step and takes no new request until the result register is free.
// ---------------------------------------------------------------------------
module mutex_condvar_thread_scheduler_top
	import mcts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // opcode[3:0], lock_id[35:4], cond_id[67:36]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // status[2:0], active_slot[6:3],
	                                        // running_valid[7], new_thread[11:8],
	                                        // library_done[12]
);

	cmd_t       cmd;
	dp_status_t sts;

	mcts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

[rtl/core/mcts_checker.sv]
// ---------------------------------------------------------------------------
// mcts_checker
// port level checks of the scheduler
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mcts_checker
	import mcts_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_acc, !s_axis_tready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_SAME(a_status_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[2:0] <= ST_FULL)
	`ASSERT_SAME(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[15:13] == 3'b000)
	`ASSERT_NEXT(a_done_sticky, clk, arst_n,
		m_axis_tvalid && m_axis_tready && m_axis_tdata[12], !m_axis_tvalid || m_axis_tdata[12])

endmodule

bind mutex_condvar_thread_scheduler_top mcts_checker u_mcts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
